// ----- rtl/core/rfa_pkg.sv -----
// Package with the shared types, codes and constants of the reduced fraction ALU.
`default_nettype none
package rfa_pkg;
  localparam int DataWidthDef = 32;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ZERO_DEN = 2'd1,
    ST_DIV_ZERO = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [31:0] a_num;
    logic signed [31:0] a_den;
    logic signed [31:0] b_num;
    logic signed [31:0] b_den;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] result_num;
    logic [30:0]        result_den;
    logic [1:0]         status;
  } out_item_t;

  // Operations of the shared unit.
  typedef enum logic [1:0] {
    UOP_MUL = 2'd0,
    UOP_DIV = 2'd1
  } uop_t;

  typedef struct packed {
    logic start;
    uop_t uop;
  } unit_ctl_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL1,
    S_MUL2,
    S_MUL3,
    S_COMBINE,
    S_GCD_START,
    S_GCD_WAIT,
    S_RED_NUM,
    S_RED_NUM_WAIT,
    S_RED_DEN,
    S_RED_DEN_WAIT,
    S_CHECK,
    S_OUT
  } state_t;
endpackage
`default_nettype wire

// ----- rtl/core/rfa_unit.sv -----
// Shared multi-cycle unit: shift-add multiplier and restoring divider, one bit a cycle.
`default_nettype none
module rfa_unit #(
  parameter int W = 64
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire rfa_pkg::unit_ctl_t ctl,
  input  wire logic [W-1:0]       op_a,
  input  wire logic [W-1:0]       op_b,
  output logic                    busy,
  output logic [W-1:0]            res_lo,
  output logic [W-1:0]            res_hi
);
  localparam int CW = $clog2(W + 1);

  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            busy_r, busy_nxt;
  rfa_pkg::uop_t   uop_r, uop_nxt;
  logic [W-1:0]    acc_r, acc_nxt;   // product or quotient
  logic [W-1:0]    rem_r, rem_nxt;   // remainder
  logic [W-1:0]    a_r, a_nxt;       // shifting multiplicand or dividend
  logic [W-1:0]    b_r, b_nxt;
  logic [W:0]      trial;

  always_comb begin
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    uop_nxt  = uop_r;
    acc_nxt  = acc_r;
    rem_nxt  = rem_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    trial    = '0;
    if (ctl.start) begin
      busy_nxt = 1'b1;
      uop_nxt  = ctl.uop;
      cnt_nxt  = CW'(W);
      acc_nxt  = '0;
      rem_nxt  = '0;
      a_nxt    = op_a;
      b_nxt    = op_b;
    end else if (busy_r) begin
      if (uop_r == rfa_pkg::UOP_MUL) begin
        // Multiplier bits are consumed from b, multiplicand a shifts left.
        if (b_r[0]) begin
          acc_nxt = acc_r + a_r;
        end
        a_nxt = a_r << 1;
        b_nxt = b_r >> 1;
      end else begin
        trial = {rem_r, a_r[W-1]} - {1'b0, b_r};
        if (!trial[W]) begin
          rem_nxt = trial[W-1:0];
          acc_nxt = {acc_r[W-2:0], 1'b1};
        end else begin
          rem_nxt = {rem_r[W-2:0], a_r[W-1]};
          acc_nxt = {acc_r[W-2:0], 1'b0};
        end
        a_nxt = a_r << 1;
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      uop_r  <= rfa_pkg::UOP_MUL;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
      uop_r  <= uop_nxt;
    end
    acc_r <= acc_nxt;
    rem_r <= rem_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
  end

  assign busy   = busy_r;
  assign res_lo = acc_r;
  assign res_hi = rem_r;
endmodule
`default_nettype wire

// ----- rtl/core/reduced_fraction_alu.sv -----
// Top level of the reduced fraction ALU: sequencer around one shared multiply/divide unit.
`default_nettype none
// Reduced fraction ALU. Each item carries two signed fractions and an opcode (add, subtract,
// multiply, divide); the block returns the exact result in lowest terms with a positive
// denominator, or 0/1 with a nonzero status for a zero operand denominator, a divide by
// zero, or a result that does not fit. All multiplies and divides run on one shared unit that
// multiplies or divides 2*DATA_WIDTH-bit magnitudes at one bit per cycle, so every
// multiply or division holds the sequencer while the unit is started, works through the
// bits and hands back its result. An item takes three multiplies, one Euclid remainder per
// gcd step (up to about 90 steps for 64-bit magnitudes) and two reducing divisions; a zero
// result skips the gcd steps and the divisions. At DATA_WIDTH=32 random operands need around
// 40 steps. Error cases go from idle straight to the output state, which raises out_valid
// once the output register is free. in_ready is high only while the sequencer is idle; a
// finished result waits in its own output register until it is taken, so the next item can
// be taken and worked on meanwhile.
module reduced_fraction_alu #(
  parameter int DATA_WIDTH = rfa_pkg::DataWidthDef
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire rfa_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output rfa_pkg::out_item_t      out_data
);
  localparam int DW = DATA_WIDTH;
  localparam int WW = 2 * DATA_WIDTH;

  rfa_pkg::state_t state_r, state_nxt;

  // Operand magnitudes and signs of the current item.
  logic [DW-1:0] an_r, ad_r, bn_r, bd_r;
  logic          sa_r, sb_r;
  logic [1:0]    op_r;
  // Products t1, t2 and den; later gcd pair p, q; num and den to reduce.
  logic [WW-1:0] t1_r, t2_r, den_r, num_r, p_r, q_r;
  logic          neg_r;
  // Result being built for the current item, and the result offered on the output.
  rfa_pkg::out_item_t res_r;
  rfa_pkg::out_item_t out_r;
  logic          out_valid_r;

  rfa_pkg::unit_ctl_t ctl;
  logic [WW-1:0] u_a, u_b, u_lo, u_hi;
  logic          u_busy;

  rfa_unit #(.W(WW)) u_unit (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl),
    .op_a   (u_a),
    .op_b   (u_b),
    .busy   (u_busy),
    .res_lo (u_lo),
    .res_hi (u_hi)
  );

  function automatic logic [DW-1:0] mag(input logic [DW-1:0] v);
    return v[DW-1] ? (~v + 1'b1) : v;
  endfunction

  logic [DW-1:0] in_an, in_ad, in_bn, in_bd;
  assign in_an = in_data.a_num[DW-1:0];
  assign in_ad = in_data.a_den[DW-1:0];
  assign in_bn = in_data.b_num[DW-1:0];
  assign in_bd = in_data.b_den[DW-1:0];

  logic in_fire, out_fire, out_free;
  assign in_ready  = (state_r == rfa_pkg::S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid_r && out_ready;
  // The output register can take a new result when it is empty or being emptied now.
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  logic          wait_done;
  logic          sb_eff;
  logic [WW-1:0] half;
  assign wait_done = !u_busy && !ctl.start;
  assign sb_eff    = (op_r == rfa_pkg::OP_SUB) ? !sb_r : sb_r;
  assign half      = WW'(1) << (DW - 1);

  // Busy flag of the unit is registered and rises in the cycle after start; started_r marks that the unit was started.
  logic started_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rfa_pkg::S_IDLE: begin
        if (in_fire) begin
          if (mag(in_ad) == '0 || mag(in_bd) == '0 ||
              (in_data.opcode == rfa_pkg::OP_DIV && in_bn == '0)) begin
            state_nxt = rfa_pkg::S_OUT;
          end else begin
            state_nxt = rfa_pkg::S_MUL1;
          end
        end
      end
      rfa_pkg::S_MUL1:         if (started_r && wait_done) state_nxt = rfa_pkg::S_MUL2;
      rfa_pkg::S_MUL2:         if (started_r && wait_done) state_nxt = rfa_pkg::S_MUL3;
      rfa_pkg::S_MUL3:         if (started_r && wait_done) state_nxt = rfa_pkg::S_COMBINE;
      rfa_pkg::S_COMBINE: begin
        state_nxt = rfa_pkg::S_GCD_START;
      end
      rfa_pkg::S_GCD_START: begin
        if (num_r == '0) begin
          state_nxt = rfa_pkg::S_OUT;
        end else if (q_r == '0) begin
          state_nxt = rfa_pkg::S_RED_NUM;
        end else begin
          state_nxt = rfa_pkg::S_GCD_WAIT;
        end
      end
      rfa_pkg::S_GCD_WAIT:     if (started_r && wait_done) state_nxt = rfa_pkg::S_GCD_START;
      rfa_pkg::S_RED_NUM:      state_nxt = rfa_pkg::S_RED_NUM_WAIT;
      rfa_pkg::S_RED_NUM_WAIT: if (started_r && wait_done) state_nxt = rfa_pkg::S_RED_DEN;
      rfa_pkg::S_RED_DEN:      state_nxt = rfa_pkg::S_RED_DEN_WAIT;
      rfa_pkg::S_RED_DEN_WAIT: if (started_r && wait_done) state_nxt = rfa_pkg::S_CHECK;
      rfa_pkg::S_CHECK:        state_nxt = rfa_pkg::S_OUT;
      rfa_pkg::S_OUT:          if (out_free) state_nxt = rfa_pkg::S_IDLE;
      default:                 state_nxt = rfa_pkg::S_IDLE;
    endcase
  end

  // Unit control: start once on entering each operation.
  always_comb begin
    ctl.start = 1'b0;
    ctl.uop   = rfa_pkg::UOP_MUL;
    u_a       = '0;
    u_b       = '0;
    unique case (state_r)
      rfa_pkg::S_MUL1: begin
        ctl.start = !started_r;
        // Add/sub and divide: an*bd; multiply: an*bn.
        u_a = WW'(an_r);
        u_b = (op_r == rfa_pkg::OP_MUL) ? WW'(bn_r) : WW'(bd_r);
      end
      rfa_pkg::S_MUL2: begin
        ctl.start = !started_r;
        // Add/sub: bn*ad, otherwise unused.
        u_a = WW'(bn_r);
        u_b = WW'(ad_r);
      end
      rfa_pkg::S_MUL3: begin
        ctl.start = !started_r;
        // Denominator: ad*bn for divide, ad*bd otherwise.
        u_a = WW'(ad_r);
        u_b = (op_r == rfa_pkg::OP_DIV) ? WW'(bn_r) : WW'(bd_r);
      end
      rfa_pkg::S_GCD_WAIT: begin
        ctl.start = !started_r;
        ctl.uop   = rfa_pkg::UOP_DIV;
        u_a = p_r;
        u_b = q_r;
      end
      rfa_pkg::S_RED_NUM_WAIT: begin
        ctl.start = !started_r;
        ctl.uop   = rfa_pkg::UOP_DIV;
        u_a = num_r;
        u_b = p_r;
      end
      rfa_pkg::S_RED_DEN_WAIT: begin
        ctl.start = !started_r;
        ctl.uop   = rfa_pkg::UOP_DIV;
        u_a = den_r;
        u_b = p_r;
      end
      default: begin
        ctl.start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rfa_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      started_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_nxt != state_r) begin
        started_r <= 1'b0;
      end else if (ctl.start) begin
        started_r <= 1'b1;
      end
      if (state_r == rfa_pkg::S_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_fire) begin
        out_valid_r <= 1'b0;
      end
    end

    if (state_r == rfa_pkg::S_OUT && out_free) begin
      out_r <= res_r;
    end

    unique case (state_r)
      rfa_pkg::S_IDLE: begin
        if (in_fire) begin
          an_r  <= mag(in_an);
          ad_r  <= mag(in_ad);
          bn_r  <= mag(in_bn);
          bd_r  <= mag(in_bd);
          sa_r  <= in_an[DW-1] ^ in_ad[DW-1];
          sb_r  <= in_bn[DW-1] ^ in_bd[DW-1];
          op_r  <= in_data.opcode;
          res_r.result_num <= '0;
          res_r.result_den <= 31'd1;
          if (mag(in_ad) == '0 || mag(in_bd) == '0) begin
            res_r.status <= rfa_pkg::ST_ZERO_DEN;
          end else if (in_data.opcode == rfa_pkg::OP_DIV && in_bn == '0) begin
            res_r.status <= rfa_pkg::ST_DIV_ZERO;
          end else begin
            res_r.status <= rfa_pkg::ST_OK;
          end
        end
      end
      rfa_pkg::S_MUL1: if (started_r && wait_done) t1_r <= u_lo;
      rfa_pkg::S_MUL2: if (started_r && wait_done) t2_r <= u_lo;
      rfa_pkg::S_MUL3: if (started_r && wait_done) den_r <= u_lo;
      rfa_pkg::S_COMBINE: begin
        if (op_r == rfa_pkg::OP_MUL || op_r == rfa_pkg::OP_DIV) begin
          num_r <= t1_r;
          p_r   <= t1_r;
          neg_r <= sa_r ^ sb_r;
        end else if (sa_r == sb_eff) begin
          num_r <= t1_r + t2_r;
          p_r   <= t1_r + t2_r;
          neg_r <= sa_r;
        end else if (t1_r >= t2_r) begin
          num_r <= t1_r - t2_r;
          p_r   <= t1_r - t2_r;
          neg_r <= sa_r;
        end else begin
          num_r <= t2_r - t1_r;
          p_r   <= t2_r - t1_r;
          neg_r <= sb_eff;
        end
        q_r <= den_r;
      end
      rfa_pkg::S_GCD_WAIT: begin
        if (started_r && wait_done) begin
          p_r <= q_r;
          q_r <= u_hi;
        end
      end
      rfa_pkg::S_RED_NUM_WAIT: if (started_r && wait_done) num_r <= u_lo;
      rfa_pkg::S_RED_DEN_WAIT: if (started_r && wait_done) den_r <= u_lo;
      rfa_pkg::S_CHECK: begin
        if (den_r > half - 1'b1 || (neg_r ? (num_r > half) : (num_r > half - 1'b1))) begin
          res_r.status <= rfa_pkg::ST_OVERFLOW;
        end else begin
          res_r.result_num <= 32'(neg_r ? (~num_r[DW-1:0] + 1'b1) : num_r[DW-1:0]);
          res_r.result_den <= 31'(den_r[DW-2:0]);
        end
      end
      default: begin
      end
    endcase
  end

  // The block only takes an item while the sequencer is idle.
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> (state_r == rfa_pkg::S_IDLE))
    else $error("item accepted while busy");
  // A result rises only in the cycle after the output state.
  a_out_after_out_state: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == rfa_pkg::S_OUT)
    else $error("result raised outside the output state");
  // The unit is never started while it is still busy.
  a_unit_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.start |-> !u_busy)
    else $error("shared unit restarted while busy");
  // A delivered result always has a nonzero denominator.
  a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_r.result_den != '0)
    else $error("zero result denominator");
endmodule
`default_nettype wire

// ----- verif/tb_reduced_fraction_alu.sv -----
// Self-checking testbench for the reduced fraction ALU: directed table plus random fractions.
`timescale 1ns / 1ps
module tb_reduced_fraction_alu;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  rfa_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  rfa_pkg::out_item_t out_data;

  reduced_fraction_alu dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  // 4 ns period.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Expected fractions, oldest first.
  rfa_pkg::out_item_t fraction_queue[$];
  int errors = 0;
  // Idle rates in percent for the sender and the receiver; changed per phase.
  int send_idle = 9;
  int recv_idle = 61;

  // Directed row: the expected result is used only when has_answer is set.
  typedef struct {
    rfa_pkg::in_item_t item;
    bit has_answer;
    rfa_pkg::out_item_t answer;
  } row_t;

  // Magnitude of a 32-bit two's complement value, as a 64-bit unsigned number.
  function automatic logic [63:0] mag_of(logic signed [31:0] v);
    logic [63:0] m;
    m = {{32{v[31]}}, v};
    if (v[31]) begin
      m = -m;
    end
    return m;
  endfunction

  // Computes the exact reduced fraction using sign-magnitude arithmetic wide enough
  // that nothing wraps, then applies the range checks on the reduced value.
  function automatic rfa_pkg::out_item_t reduce_fraction(rfa_pkg::in_item_t it);
    rfa_pkg::out_item_t r;
    logic [63:0] an, ad, bn, bd, t1, t2, num, den, p, q, t;
    bit sa, sb, neg;
    r = '{result_num: 0, result_den: 1, status: rfa_pkg::ST_OK};
    an = mag_of(it.a_num);
    ad = mag_of(it.a_den);
    bn = mag_of(it.b_num);
    bd = mag_of(it.b_den);
    // A zero operand denominator outranks every other condition.
    if (ad == 0 || bd == 0) begin
      r.status = rfa_pkg::ST_ZERO_DEN;
      return r;
    end
    if (it.opcode == rfa_pkg::OP_DIV && bn == 0) begin
      r.status = rfa_pkg::ST_DIV_ZERO;
      return r;
    end
    sa = it.a_num[31] ^ it.a_den[31];
    sb = it.b_num[31] ^ it.b_den[31];
    case (it.opcode)
      rfa_pkg::OP_ADD, rfa_pkg::OP_SUB: begin
        t1 = an * bd;
        t2 = bn * ad;
        if (it.opcode == rfa_pkg::OP_SUB) begin
          sb = !sb;
        end
        den = ad * bd;
        if (sa == sb) begin
          num = t1 + t2;
          neg = sa;
        end else if (t1 >= t2) begin
          num = t1 - t2;
          neg = sa;
        end else begin
          num = t2 - t1;
          neg = sb;
        end
      end
      rfa_pkg::OP_MUL: begin
        num = an * bn;
        den = ad * bd;
        neg = sa ^ sb;
      end
      default: begin
        num = an * bd;
        den = ad * bn;
        neg = sa ^ sb;
      end
    endcase
    // Zero result is 0/1 regardless of sign.
    if (num == 0) begin
      return r;
    end
    p = num;
    q = den;
    while (q != 0) begin
      t = p % q;
      p = q;
      q = t;
    end
    num = num / p;
    den = den / p;
    if (den > 64'h7fff_ffff || num > (neg ? 64'h8000_0000 : 64'h7fff_ffff)) begin
      r.status = rfa_pkg::ST_OVERFLOW;
      return r;
    end
    r.result_num = neg ? -num[31:0] : num[31:0];
    r.result_den = den[30:0];
    return r;
  endfunction

  function automatic logic signed [31:0] rand_field();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 12) - 6;
      1: return $urandom_range(1, 1000);
      2: return -$signed($urandom_range(1, 1000));
      3: return $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
      4: return $signed($urandom_range(0, 65535)) - 32768;
      default: return $urandom();
    endcase
  endfunction

  // Presents one item and holds it until the block takes it.
  task automatic send_item(rfa_pkg::in_item_t it, bit has_answer,
                           rfa_pkg::out_item_t answer);
    bit idle;
    idle = ($urandom_range(0, 99) < send_idle);
    if (idle) begin
      in_valid <= 1'b0;
    end
    while (idle) begin
      @(posedge clk);
      idle = ($urandom_range(0, 99) < send_idle);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    // Directed rows with a typed answer are also cross-checked against the predictor.
    if (has_answer && answer != reduce_fraction(it)) begin
      $display("%0t: table row disagrees with predictor: expected %p actual %p",
               $time, answer, reduce_fraction(it));
      errors++;
    end
    fraction_queue.push_back(has_answer ? answer : reduce_fraction(it));
  endtask

  // Receiver: ready toggles at random; each accepted result is checked.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (fraction_queue.size() == 0) begin
          $display("%0t: unexpected result %p", $time, out_data);
          errors++;
        end else begin
          rfa_pkg::out_item_t want;
          want = fraction_queue.pop_front();
          if (out_data.result_num !== want.result_num) begin
            $display("%0t: result_num expected %0d actual %0d", $time,
                     want.result_num, out_data.result_num);
            errors++;
          end
          if (out_data.result_den !== want.result_den) begin
            $display("%0t: result_den expected %0d actual %0d", $time,
                     want.result_den, out_data.result_den);
            errors++;
          end
          if (out_data.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time,
                     want.status, out_data.status);
            errors++;
          end
        end
      end
      out_ready <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  localparam rfa_pkg::out_item_t ZeroDenAns =
    '{result_num: 0, result_den: 1, status: rfa_pkg::ST_ZERO_DEN};
  localparam rfa_pkg::out_item_t DivZeroAns =
    '{result_num: 0, result_den: 1, status: rfa_pkg::ST_DIV_ZERO};
  localparam rfa_pkg::out_item_t OverAns =
    '{result_num: 0, result_den: 1, status: rfa_pkg::ST_OVERFLOW};
  localparam rfa_pkg::out_item_t ZeroAns =
    '{result_num: 0, result_den: 1, status: rfa_pkg::ST_OK};

  initial begin
    row_t dir_table[22];
    rfa_pkg::in_item_t it;
    int phase;
    int n;
    // Directed table: extremes, every operation, each error and the zero result.
    dir_table = '{
      '{'{rfa_pkg::OP_ADD, 1, 2, 1, 3}, 0, ZeroAns},
      '{'{rfa_pkg::OP_SUB, 1, 2, 1, 3}, 0, ZeroAns},
      '{'{rfa_pkg::OP_MUL, -2, 3, 3, -4}, 0, ZeroAns},
      '{'{rfa_pkg::OP_DIV, 5, -7, -3, 2}, 0, ZeroAns},
      '{'{rfa_pkg::OP_ADD, 1, 0, 1, 1}, 1, ZeroDenAns},
      '{'{rfa_pkg::OP_DIV, 1, 1, 0, 0}, 1, ZeroDenAns},
      '{'{rfa_pkg::OP_MUL, 3, 5, 7, 0}, 1, ZeroDenAns},
      '{'{rfa_pkg::OP_DIV, 3, 5, 0, 9}, 1, DivZeroAns},
      '{'{rfa_pkg::OP_DIV, 0, 5, 0, -9}, 1, DivZeroAns},
      '{'{rfa_pkg::OP_SUB, 3, 4, 6, 8}, 1, ZeroAns},
      '{'{rfa_pkg::OP_MUL, 0, -5, 7, 3}, 1, ZeroAns},
      '{'{rfa_pkg::OP_ADD, -3, 4, 3, 4}, 1, ZeroAns},
      '{'{rfa_pkg::OP_ADD, 32'sh7fff_ffff, 1, 1, 1}, 1, OverAns},
      '{'{rfa_pkg::OP_MUL, 32'sh8000_0000, 1, -1, 1}, 1, OverAns},
      '{'{rfa_pkg::OP_MUL, 32'sh8000_0000, 1, 1, 1}, 0, ZeroAns},
      '{'{rfa_pkg::OP_DIV, 1, 32'sh8000_0000, 1, 1}, 1, OverAns},
      '{'{rfa_pkg::OP_DIV, 1, 32'sh7fff_ffff, 1, 32'sh7fff_ffff}, 0, ZeroAns},
      '{'{rfa_pkg::OP_SUB, 32'sh8000_0000, 32'sh8000_0000,
          32'sh7fff_ffff, 32'sh7fff_ffff}, 1, ZeroAns},
      '{'{rfa_pkg::OP_ADD, 32'sh7fff_ffff, 32'sh7fff_ffff,
          -1, 32'sh8000_0000}, 0, ZeroAns},
      '{'{rfa_pkg::OP_MUL, 32'sh7fff_ffff, 2, 2, 32'sh7fff_ffff}, 0, ZeroAns},
      '{'{rfa_pkg::OP_DIV, -1, -1, -1, -1}, 0, ZeroAns},
      '{'{rfa_pkg::OP_SUB, 32'shffff_ffff, 32'sh0000_0001,
          32'sh5555_5555, 32'shaaaa_aaaa}, 0, ZeroAns}
    };
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (dir_table[i]) begin
      send_item(dir_table[i].item, dir_table[i].has_answer, dir_table[i].answer);
    end
    // Three idling phases of random items; most are valid fractions, a few hit errors.
    for (phase = 0; phase < 3; phase++) begin
      send_idle = (phase == 0) ? 9 : (phase == 1) ? 61 : 0;
      recv_idle = (phase == 0) ? 61 : (phase == 1) ? 9 : 0;
      for (n = 0; n < 160; n++) begin
        it.opcode = rfa_pkg::op_t'($urandom_range(0, 3));
        it.a_num = rand_field();
        it.a_den = rand_field();
        it.b_num = rand_field();
        it.b_den = rand_field();
        // Keep zero denominators rare so most items reach the gcd path.
        if ($urandom_range(0, 19) != 0) begin
          if (it.a_den == 0) it.a_den = 1;
          if (it.b_den == 0) it.b_den = -1;
        end
        send_item(it, 0, ZeroAns);
      end
    end
    in_valid <= 1'b0;
    while (fraction_queue.size() != 0) begin
      @(posedge clk);
    end
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("tb_reduced_fraction_alu passed");
    end else begin
      $display("tb_reduced_fraction_alu failed");
    end
    $finish;
  end

  // Slowest run: about 500 items, each a long gcd sequence, plus stalls; allow several times that.
  initial begin
    #100_000_000;
    $display("tb_reduced_fraction_alu failed");
    $finish;
  end
endmodule

// ----- filelist.f -----
rtl/core/rfa_pkg.sv
rtl/core/rfa_unit.sv
rtl/core/reduced_fraction_alu.sv
verif/tb_reduced_fraction_alu.sv
